>>> src/dmrb_pkg.sv
package dmrb_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 64;

  // fixed field widths of the channels
  localparam int ITEM_W   = 64;
  localparam int STATUS_W = 2;
  localparam int RSIZE_W  = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // register indexes (taken from paddr[2])
  localparam logic REG_ASYNC_MODE = 1'b0;
  localparam logic REG_RING_SIZE  = 1'b1;

  localparam logic               ASYNC_MODE_RST = 1'b0;
  localparam logic [RSIZE_W-1:0] RING_SIZE_RST  = 8'd128;
  localparam int                 RING_MIN       = 2;

  // access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NODATA = 2'd3;

endpackage

>>> src/dmrb_if.sv
interface dmrb_req_if import dmrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ITEM_W-1:0] item;

  modport source(output valid, mode, item, input ready);
  modport sink(input valid, mode, item, output ready);
endinterface

interface dmrb_rsp_if import dmrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ITEM_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;

  modport source(output valid, read_data, status, input ready);
  modport sink(input valid, read_data, status, output ready);
endinterface

>>> src/dmrb_ram.sv
module dmrb_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dual_mode_four_slot_or_ring_buffer_unit.sv
// A result is loaded into the output register in the cycle after its item is accepted
// (the synchronous store read is done when the item is accepted, and its data then go to the output register).
// Items are not taken back to back: no new item is taken while the store read of the one in
// flight completes, nor while a result waits in the output register and is not taken.
// Reset (rst, synchronous): mode, ring size, pointers, pair flags and valids go to reset
// values; the store itself is not cleared and needs no clearing pass.
module dual_mode_four_slot_or_ring_buffer_unit import dmrb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dmrb_req_if.sink          req,
  dmrb_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = PW + 1;
  localparam int CW = (NW > RSIZE_W) ? NW : RSIZE_W;

  // configuration
  logic               async_mode;
  logic [RSIZE_W-1:0] ring_size;

  // control state
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic          latest_pair;
  logic          reading_pair;
  logic [1:0]    last_slot;
  logic          any_written;

  // item in flight and output register
  logic                pend;
  logic                pend_rd;
  logic [STATUS_W-1:0] pend_status;
  logic                out_valid;
  logic [ITEM_W-1:0]   out_data;
  logic [STATUS_W-1:0] out_status;

  logic                  cfg_wr;
  logic                  acc;
  logic [CW-1:0]         rs_c;
  logic [CW-1:0]         n_c;
  logic [NW-1:0]         ring_n;
  logic [NW-1:0]         wp_inc;
  logic [NW-1:0]         rp_inc;
  logic [PW-1:0]         wp_next;
  logic [PW-1:0]         rp_next;
  logic                  wr_pair;
  logic                  wr_slot;
  logic                  rd_pair;
  logic                  rd_slot;
  logic                  mem_we;
  logic                  mem_re;
  logic [PW-1:0]         waddr;
  logic [PW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [STATUS_W-1:0]   st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RING_SIZE) ? APB_DW'(ring_size) : APB_DW'(async_mode);

  assign req.ready     = !pend && (!out_valid || rsp.ready);
  assign acc           = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

  // effective ring length, clamped to [2, DEPTH]
  always_comb begin
    rs_c = CW'(ring_size);
    if (rs_c < CW'(RING_MIN)) begin
      n_c = CW'(RING_MIN);
    end else if (rs_c > CW'(DEPTH)) begin
      n_c = CW'(DEPTH);
    end else begin
      n_c = rs_c;
    end
    ring_n = n_c[NW-1:0];
  end

  assign wp_inc  = {1'b0, wp} + NW'(1);
  assign rp_inc  = {1'b0, rp} + NW'(1);
  assign wp_next = (wp_inc == ring_n) ? '0 : wp_inc[PW-1:0];
  assign rp_next = (rp_inc == ring_n) ? '0 : rp_inc[PW-1:0];

  // four-slot: writer takes the pair not being read and its other slot
  assign wr_pair = ~reading_pair;
  assign wr_slot = ~last_slot[wr_pair];
  assign rd_pair = latest_pair;
  assign rd_slot = last_slot[rd_pair];

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = wp;
    raddr  = rp;
    st     = ST_OK;
    if (async_mode) begin
      waddr = PW'({wr_pair, wr_slot});
      raddr = PW'({rd_pair, rd_slot});
      if (req.mode == ACC_WRITE) begin
        mem_we = acc;
      end else if (!any_written) begin
        st = ST_NODATA;
      end else begin
        mem_re = acc;
      end
    end else begin
      if (req.mode == ACC_WRITE) begin
        if (wp_next == rp) begin
          st = ST_FULL;
        end else begin
          mem_we = acc;
        end
      end else if (rp == wp) begin
        st = ST_EMPTY;
      end else begin
        mem_re = acc;
      end
    end
  end

  dmrb_ram #(
    .DEPTH(DEPTH),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(req.item[DATA_WIDTH-1:0]),
    .re   (mem_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      async_mode   <= ASYNC_MODE_RST;
      ring_size    <= RING_SIZE_RST;
      wp           <= '0;
      rp           <= '0;
      latest_pair  <= 1'b0;
      reading_pair <= 1'b0;
      last_slot    <= '0;
      any_written  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RING_SIZE) begin
        ring_size <= pwdata[RSIZE_W-1:0];
      end else begin
        async_mode <= pwdata[0];
      end
      wp           <= '0;
      rp           <= '0;
      latest_pair  <= 1'b0;
      reading_pair <= 1'b0;
      last_slot    <= '0;
      any_written  <= 1'b0;
    end else if (acc) begin
      if (mem_we) begin
        any_written <= 1'b1;
        if (async_mode) begin
          last_slot[wr_pair] <= wr_slot;
          latest_pair        <= wr_pair;
        end else begin
          wp <= wp_next;
        end
      end
      if (mem_re) begin
        if (async_mode) begin
          reading_pair <= rd_pair;
        end else begin
          rp <= rp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= acc;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (pend) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_rd     <= mem_re;
      pend_status <= st;
    end
    if (pend) begin
      out_data   <= pend_rd ? ITEM_W'(rdata) : '0;
      out_status <= pend_status;
    end
  end

  a_acc_pend: assert property (@(posedge clk) disable iff (rst) acc |=> pend)
    else $error("accepted item did not enter the read stage");

  a_pend_out: assert property (@(posedge clk) disable iff (rst) pend |=> out_valid)
    else $error("result not loaded into the output register");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) pend |-> !req.ready)
    else $error("new item accepted while one is in flight");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
      !async_mode |-> (({1'b0, wp} < ring_n) && ({1'b0, rp} < ring_n)))
    else $error("ring pointer beyond ring length");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dmrb_pkg::*;

  localparam int   SETTLE_CYCLES = 6;
  localparam int   WATCHDOG_NS   = 5_000_000;
  localparam logic [ITEM_W-1:0] ONES = '1;

  typedef struct packed {
    logic [ITEM_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [1:0] {ROW_ACCESS, ROW_CFG_MODE, ROW_CFG_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                mode;
    logic [ITEM_W-1:0]   value;
    logic                typed;
    logic [ITEM_W-1:0]   want_data;
    logic [STATUS_W-1:0] want_status;
  } dir_row_t;

  localparam int N_DIR = 26;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // ring mode out of reset, 128 entries
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_EMPTY},
    '{ROW_ACCESS,   ACC_WRITE, 64'h0,                  1'b1, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, ONES,                   1'b1, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h5555_5555_5555_5555, 1'b1, ONES,  ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_EMPTY},
    // size below the minimum acts as two: room for a single word
    '{ROW_CFG_SIZE, ACC_READ,  64'd0,                  1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, 64'h0123_4567_89AB_CDEF, 1'b1, 64'h0, ST_FULL},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'hA5A5_A5A5_A5A5_A5A5, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_EMPTY},
    '{ROW_ACCESS,   ACC_WRITE, 64'h8000_0000_0000_0001, 1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b0, 64'h0, ST_OK},
    // four-slot mode
    '{ROW_CFG_MODE, ACC_READ,  64'd1,                  1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_NODATA},
    '{ROW_ACCESS,   ACC_WRITE, 64'h8000_0000_0000_0001, 1'b1, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h8000_0000_0000_0001, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  ONES,                   1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_WRITE, ONES,                   1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b0, 64'h0, ST_OK},
    // a size write also clears the flags: no data again
    '{ROW_CFG_SIZE, ACC_READ,  64'd255,                1'b0, 64'h0, ST_OK},
    '{ROW_ACCESS,   ACC_READ,  64'h0,                  1'b1, 64'h0, ST_NODATA},
    '{ROW_CFG_MODE, ACC_READ,  64'd0,                  1'b0, 64'h0, ST_OK}
  };

  // random phases; size -1 draws any 8-bit value
  localparam int N_PHASES = 10;
  localparam int PH_ASYNC [N_PHASES] = '{0, 0, 0, 1, 0, 0, 1, 0, 0, 1};
  localparam int PH_SIZE  [N_PHASES] = '{2, 3, 255, 128, 1, 128, 0, 9, -1, -1};
  localparam int PH_ITEMS [N_PHASES] = '{90, 90, 300, 150, 60, 280, 150, 120, 200, 90};
  localparam int PH_BUSY  [N_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dmrb_req_if req_ch ();
  dmrb_rsp_if rsp_ch ();

  dual_mode_four_slot_or_ring_buffer_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the buffer state
  logic [ITEM_W-1:0]  shadow_mem [DEPTH_DEF];
  int                 wr_ptr;
  int                 rd_ptr;
  logic               latest_pair;
  logic               reading_pair;
  logic               last_slot [2];
  logic               any_written;
  logic               async_cfg;
  logic [RSIZE_W-1:0] ring_cfg;

  result_t results_due [$];
  int      err_count = 0;
  bit      no_idle = 1'b0;

  function automatic void clear_control();
    wr_ptr       = 0;
    rd_ptr       = 0;
    latest_pair  = 1'b0;
    reading_pair = 1'b0;
    last_slot[0] = 1'b0;
    last_slot[1] = 1'b0;
    any_written  = 1'b0;
  endfunction

  function automatic void apply_cfg(input logic idx, input logic [APB_DW-1:0] val);
    if (idx == REG_ASYNC_MODE) async_cfg = val[0];
    else ring_cfg = val[RSIZE_W-1:0];
    clear_control();
  endfunction

  function automatic int ring_len();
    int n;
    n = int'(ring_cfg);
    if (n < RING_MIN) n = RING_MIN;
    if (n > DEPTH_DEF) n = DEPTH_DEF;
    return n;
  endfunction

  function automatic void predict_access(input logic m, input logic [ITEM_W-1:0] w,
                                         output result_t r);
    int   nxt;
    logic pair;
    logic slot;
    r.read_data = '0;
    r.status    = ST_OK;
    if (async_cfg) begin
      if (m == ACC_WRITE) begin
        // write into the pair the reader is not on, slot not written last
        pair = ~reading_pair;
        slot = ~last_slot[pair];
        shadow_mem[int'({pair, slot})] = w;
        last_slot[pair] = slot;
        latest_pair     = pair;
        any_written     = 1'b1;
      end else if (!any_written) begin
        r.status = ST_NODATA;
      end else begin
        pair         = latest_pair;
        slot         = last_slot[pair];
        reading_pair = pair;
        r.read_data  = shadow_mem[int'({pair, slot})];
      end
    end else begin
      if (m == ACC_WRITE) begin
        nxt = (wr_ptr + 1) % ring_len();
        if (nxt == rd_ptr) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[wr_ptr] = w;
          wr_ptr      = nxt;
          any_written = 1'b1;
        end
      end else if (rd_ptr == wr_ptr) begin
        r.status = ST_EMPTY;
      end else begin
        r.read_data = shadow_mem[rd_ptr];
        rd_ptr      = (rd_ptr + 1) % ring_len();
      end
    end
  endfunction

  function automatic logic [ITEM_W-1:0] rand_word();
    unique case ($urandom_range(0, 15))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_access(input logic m, input logic [ITEM_W-1:0] w, input logic typed,
                             input result_t want);
    int      gap;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.item  <= w;
    do @(posedge clk); while (!req_ch.ready);
    predict_access(m, w, r);
    if (typed) r = want;
    results_due.push_back(r);
  endtask

  // hold off new items until every result is back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read the register back; ends with the port idle
  task automatic program_reg(input logic idx, input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_cfg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (idx == REG_RING_SIZE) ? APB_DW'(val[RSIZE_W-1:0]) : APB_DW'(val[0]);
    if (rd !== want) begin
      $error("prdata (reg %0d): expected %h, got %h", idx, want, rd);
      err_count++;
    end
    @(posedge clk);
  endtask

  initial begin : stimulus
    int      sent;
    int      run_len;
    int      kind;
    int      n_runs;
    int      size;
    logic    m;
    result_t want;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= ACC_READ;
    req_ch.item  <= '0;
    async_cfg = ASYNC_MODE_RST;
    ring_cfg  = RING_SIZE_RST;
    clear_control();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      unique case (DIR_ROWS[i].kind)
        ROW_CFG_MODE: begin
          wait_idle();
          program_reg(REG_ASYNC_MODE, DIR_ROWS[i].value[APB_DW-1:0]);
        end
        ROW_CFG_SIZE: begin
          wait_idle();
          program_reg(REG_RING_SIZE, DIR_ROWS[i].value[APB_DW-1:0]);
        end
        default: begin
          want = '{DIR_ROWS[i].want_data, DIR_ROWS[i].want_status};
          send_access(DIR_ROWS[i].mode, DIR_ROWS[i].value, DIR_ROWS[i].typed, want);
        end
      endcase
    end

    want = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      size = (PH_SIZE[p] < 0) ? $urandom_range(0, 255) : PH_SIZE[p];
      if ($urandom_range(0, 1)) begin
        program_reg(REG_ASYNC_MODE, APB_DW'(PH_ASYNC[p]));
        program_reg(REG_RING_SIZE, APB_DW'(size));
      end else begin
        program_reg(REG_RING_SIZE, APB_DW'(size));
        program_reg(REG_ASYNC_MODE, APB_DW'(PH_ASYNC[p]));
      end
      no_idle = PH_BUSY[p] != 0;
      sent    = 0;
      n_runs  = 0;
      while (sent < PH_ITEMS[p]) begin
        // ring phases open with a full fill and a full drain, then random runs
        if (!async_cfg && n_runs < 2) begin
          run_len = ring_len() + 1;
          kind    = n_runs * 4;
        end else begin
          run_len = async_cfg ? $urandom_range(1, 8) : $urandom_range(1, ring_len() + 1);
          kind    = $urandom_range(0, 9);
        end
        for (int k = 0; k < run_len && sent < PH_ITEMS[p]; k++) begin
          if (kind < 4) m = ACC_WRITE;
          else if (kind < 8) m = ACC_READ;
          else m = 1'($urandom_range(0, 1));
          send_access(m, rand_word(), 1'b0, want);
          sent++;
          if (sent == 40 || $urandom_range(0, 150) == 0) wait_idle();
        end
        n_runs++;
      end
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_checker
    result_t want;
    int      stall;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (results_due.size() == 0) begin
        $error("unexpected result: read_data %h, status %0d", rsp_ch.read_data,
               rsp_ch.status);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (rsp_ch.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp_ch.read_data);
          err_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
